// ===== design/primitive_exponent_check_assert.svh =====
// Assertion macros for the primitive exponent check block.
// Used by the port-level checker; expects clk and rst in scope.
`ifndef PRIMITIVE_EXPONENT_CHECK_ASSERT_SVH
`define PRIMITIVE_EXPONENT_CHECK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PEC_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PEC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/pec_pkg.sv =====
// Shared types and constants for the primitive exponent check block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

  localparam int EXP_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/pec_step_unit.sv =====
// Shift-compare-subtract step: rem' = (2*rem + shift_in) mod divisor, for rem < divisor.
// Serves both the restoring remainder and the modular doubling. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pec_step_unit #(
  parameter int W = 64
) (
  input  logic [W-1:0] rem,
  input  logic         shift_in,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] rem_next
);

  logic [W:0] wide;
  logic [W:0] diff;
  logic       fits;

  always_comb begin
    wide     = {rem, shift_in};
    diff     = wide - {1'b0, divisor};
    fits     = (wide >= {1'b0, divisor});
    rem_next = fits ? diff[W-1:0] : wide[W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/primitive_exponent_check.sv =====
// Top level of the primitive exponent check block: sequencer and datapath.
// Depends on pec_pkg and pec_step_unit.
//
// Usage: an item (value, exponent, modulus) transfers when item_valid is high and
// item_stall is low. The answer is_primitive transfers on the result channel the
// same way (result_valid / result_stall); exactly one result per item, in order.
// One step unit does all the arithmetic. It first reduces value mod modulus,
// one dividend bit a cycle, then walks 2^j mod modulus by doubling, one power a
// cycle, stopping at the first match or at j = exponent, then hands the answer
// to the output register from ST_DONE, holding there while the output is full.
// A zero exponent, a modulus below two or an exponent above MAX_EXPONENT goes
// straight from idle to ST_DONE. item_stall is high while an item is in work.
// The output register lets the next item start while a result waits; if the
// receiver stalls and a new answer is ready, the sequencer holds until the
// output register frees. Reset empties the output and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module primitive_exponent_check
  import pec_pkg::*;
#(
  parameter int DATA_WIDTH   = 64,
  parameter int MAX_EXPONENT = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [EXP_W-1:0]      exponent,
  input  logic [DATA_WIDTH-1:0] modulus,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  is_primitive
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  state_t                state;
  state_t                state_next;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] target;
  logic [DATA_WIDTH-1:0] mod_r;
  logic [EXP_W-1:0]      exp_r;
  logic [EXP_W-1:0]      step;
  logic [CNT_W-1:0]      cnt;
  logic                  hit;

  logic                  unit_bit;
  logic [DATA_WIDTH-1:0] unit_out;
  logic                  hit_now;
  logic                  out_free;
  logic                  trivial;

  pec_step_unit #(
    .W(DATA_WIDTH)
  ) u_step (
    .rem     (acc),
    .shift_in(unit_bit),
    .divisor (mod_r),
    .rem_next(unit_out)
  );

  assign hit_now  = (unit_out == target);
  assign out_free = !result_valid || !result_stall;
  assign trivial  = (exponent == '0) || (modulus < DATA_WIDTH'(2)) ||
                    (exponent > EXP_W'(MAX_EXPONENT));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = trivial ? ST_DONE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (cnt == '0) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit_now || (step == exp_r)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_stall = 1'b1;
    unit_bit   = 1'b0;
    unique case (state)
      ST_IDLE:   item_stall = 1'b0;
      ST_DIVIDE: unit_bit   = dividend[DATA_WIDTH-1];
      ST_WALK:   unit_bit   = 1'b0;
      ST_DONE:   unit_bit   = 1'b0;
      default:   item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          dividend <= value;
          mod_r    <= modulus;
          exp_r    <= exponent;
          acc      <= '0;
          cnt      <= CNT_W'(DATA_WIDTH - 1);
          hit      <= 1'b0;
        end
      end
      ST_DIVIDE: begin
        dividend <= dividend << 1;
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          target <= unit_out;
          acc    <= DATA_WIDTH'(1);
          step   <= EXP_W'(1);
        end else begin
          acc <= unit_out;
        end
      end
      ST_WALK: begin
        acc  <= unit_out;
        step <= step + 1'b1;
        if (hit_now) begin
          hit <= (step == exp_r);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          is_primitive <= hit;
        end
      end
      default: hit <= 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pec_checker.sv =====
// Port-level checker for primitive_exponent_check, bound to the top level.
// Depends on primitive_exponent_check_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "primitive_exponent_check_assert.svh"

module pec_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_stall,
  input logic result_valid,
  input logic result_stall,
  input logic is_primitive
);

  // A stalled result holds.
  `PEC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(is_primitive), "stalled result changed")

  // An item transfer makes the block busy.
  `PEC_ASSERT_NEXT(a_busy_after_transfer, item_valid && !item_stall, item_stall, "not busy after item transfer")

  // A new result appears only as the sequencer returns to idle.
  `PEC_ASSERT_SAME(a_result_at_idle, $rose(result_valid), !item_stall, "result appeared while busy")

endmodule

bind primitive_exponent_check pec_checker u_pec_checker (.*);

`default_nettype wire
